// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/agc_pkg.sv -----
// ----------------------------------------------------------------------------
// agc_pkg
// Constants, register indexes and reset values of the gain control block.
// ----------------------------------------------------------------------------
package agc_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_LEVEL    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_SMOOTHING = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_SMOOTHING  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_GAIN        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_GAIN        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_FLOOR     = 3'd5;

   localparam logic [14:0] TARGET_LEVEL_RESET    = 15'd26214;
   localparam logic [15:0] LEVEL_SMOOTHING_RESET = 16'd62259;
   localparam logic [15:0] GAIN_SMOOTHING_RESET  = 16'd58982;
   localparam logic [15:0] MIN_GAIN_RESET        = 16'd4096;
   localparam logic [15:0] MAX_GAIN_RESET        = 16'd40960;
   localparam logic [14:0] LEVEL_FLOOR_RESET     = 15'd3;

   localparam logic [15:0] UNITY_GAIN   = 16'd4096;
   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [15:0] GAIN_SAT     = 16'hFFFF;
   localparam int          DIV_STEPS    = 16;

endpackage

// ----- hw/rtl/adaptive_gain_control.sv -----
// ----------------------------------------------------------------------------
// adaptive_gain_control
// Envelope-following gain control with one shared 18x18 multiply-accumulate
// unit and a radix-2 restoring divider for target / envelope.
// A request is accepted only in the idle state, so a new sample waits until the
// previous result has been handed off; the handoff stalls while an earlier
// response still waits for rsp_ready. Each sample runs through the 16 divider
// steps, the 5 passes through the shared multiplier and the accumulate, clamp,
// handoff and idle steps.
// Reset: registers take their defaults, envelope clears, gain returns to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adaptive_gain_control
   import agc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [19:0]             rsp_sample_out,
   output logic        [15:0]             rsp_gain_now,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_ENV1 = 13'b0000000000010,
      ST_ENV2 = 13'b0000000000100,
      ST_ENV3 = 13'b0000000001000,
      ST_ENVF = 13'b0000000010000,
      ST_DIVI = 13'b0000000100000,
      ST_DIV  = 13'b0000001000000,
      ST_G1   = 13'b0000010000000,
      ST_G2   = 13'b0000100000000,
      ST_G3   = 13'b0001000000000,
      ST_G4   = 13'b0010000000000,
      ST_YMUL = 13'b0100000000000,
      ST_OUT  = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;

   logic [14:0]        target_ff, target_in;
   logic [15:0]        lsmooth_ff, lsmooth_in;
   logic [15:0]        gsmooth_ff, gsmooth_in;
   logic [15:0]        min_gain_ff, min_gain_in;
   logic [15:0]        max_gain_ff, max_gain_in;
   logic [14:0]        floor_ff, floor_in;

   logic [15:0]        env_ff, env_in;
   logic [15:0]        gain_ff, gain_in;

   logic signed [15:0] samp_ff, samp_in;
   logic [16:0]        mag_ff, mag_in;
   logic signed [35:0] prod_ff, prod_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic [3:0]         cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [19:0] rsp_sample_ff, rsp_sample_in;
   logic [15:0]        rsp_gain_ff, rsp_gain_in;

   logic signed [17:0] mul_a, mul_b;
   logic signed [SAMPLE_WIDTH+15:0] samp_wide;
   logic signed [15:0] samp_align;
   logic [16:0]        samp_ext;
   logic [15:0]        floor_eff;
   logic [15:0]        env_raw;
   logic [15:0]        gain_raw;
   logic [15:0]        des;
   logic [16:0]        rem_shift;
   logic               rem_ge;
   logic               out_free;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_gain_now   = rsp_gain_ff;

   assign samp_wide  = {req_sample_in, 16'b0};
   assign samp_align = samp_wide[SAMPLE_WIDTH+15:SAMPLE_WIDTH];
   assign samp_ext   = {samp_align[15], samp_align};
   assign floor_eff  = (floor_ff == '0) ? 16'd1 : {1'b0, floor_ff};
   assign env_raw    = acc_ff[31:16];
   assign gain_raw   = acc_ff[31:16];
   assign des        = sat_ff ? GAIN_SAT : quo_ff;
   assign rem_shift  = {rem_ff, quo_ff[15]};
   assign rem_ge     = (rem_shift >= {1'b0, env_ff});
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ENV1: begin
            mul_a = {2'b0, lsmooth_ff};
            mul_b = {2'b0, env_ff};
         end
         ST_ENV2: begin
            mul_a = {1'b0, ONE_Q16 - {1'b0, lsmooth_ff}};
            mul_b = {1'b0, mag_ff};
         end
         ST_G1: begin
            mul_a = {2'b0, gsmooth_ff};
            mul_b = {2'b0, gain_ff};
         end
         ST_G2: begin
            mul_a = {1'b0, ONE_Q16 - {1'b0, gsmooth_ff}};
            mul_b = {2'b0, des};
         end
         ST_YMUL, ST_OUT: begin
            mul_a = {{2{samp_ff[15]}}, samp_ff};
            mul_b = {2'b0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      lsmooth_in    = lsmooth_ff;
      gsmooth_in    = gsmooth_ff;
      min_gain_in   = min_gain_ff;
      max_gain_in   = max_gain_ff;
      floor_in      = floor_ff;
      env_in        = env_ff;
      gain_in       = gain_ff;
      samp_in       = samp_ff;
      mag_in        = mag_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      sat_in        = sat_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_gain_in   = rsp_gain_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_LEVEL:    target_in   = csr_wdata[14:0];
            CSR_LEVEL_SMOOTHING: lsmooth_in  = csr_wdata;
            CSR_GAIN_SMOOTHING:  gsmooth_in  = csr_wdata;
            CSR_MIN_GAIN:        min_gain_in = csr_wdata;
            CSR_MAX_GAIN:        max_gain_in = csr_wdata;
            CSR_LEVEL_FLOOR:     floor_in    = csr_wdata[14:0];
            default:             ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_in  = samp_align;
               mag_in   = samp_ext[16] ? (17'd0 - samp_ext) : samp_ext;
               state_in = ST_ENV1;
            end
         end
         ST_ENV1: state_in = ST_ENV2;
         ST_ENV2: begin
            acc_in   = prod_ff + 36'sd32768;
            state_in = ST_ENV3;
         end
         ST_ENV3: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_ENVF;
         end
         ST_ENVF: begin
            env_in   = (env_raw < floor_eff) ? floor_eff : env_raw;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            sat_in   = ({5'b0, target_ff} >= {env_ff, 4'b0});
            rem_in   = {5'b0, target_ff[14:4]};
            quo_in   = {target_ff[3:0], 12'b0};
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = rem_ge ? 16'(rem_shift - {1'b0, env_ff}) : rem_shift[15:0];
            quo_in = {quo_ff[14:0], rem_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               state_in = ST_G1;
            end
         end
         ST_G1: state_in = ST_G2;
         ST_G2: begin
            acc_in   = prod_ff + 36'sd32768;
            state_in = ST_G3;
         end
         ST_G3: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_G4;
         end
         ST_G4: begin
            if (gain_raw < min_gain_ff) begin
               gain_in = min_gain_ff;
            end else if (gain_raw > max_gain_ff) begin
               gain_in = max_gain_ff;
            end else begin
               gain_in = gain_raw;
            end
            state_in = ST_YMUL;
         end
         ST_YMUL: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = prod_ff[31:12];
               rsp_gain_in   = gain_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_LEVEL_RESET;
         lsmooth_ff   <= LEVEL_SMOOTHING_RESET;
         gsmooth_ff   <= GAIN_SMOOTHING_RESET;
         min_gain_ff  <= MIN_GAIN_RESET;
         max_gain_ff  <= MAX_GAIN_RESET;
         floor_ff     <= LEVEL_FLOOR_RESET;
         env_ff       <= '0;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         lsmooth_ff   <= lsmooth_in;
         gsmooth_ff   <= gsmooth_in;
         min_gain_ff  <= min_gain_in;
         max_gain_ff  <= max_gain_in;
         floor_ff     <= floor_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      samp_ff       <= samp_in;
      mag_ff        <= mag_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      sat_ff        <= sat_in;
      cnt_ff        <= cnt_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_gain_ff   <= rsp_gain_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "block still ready after accepting a transaction")

   `ASSERT_IMPLIES(a_env_range, clock, reset, state_ff == ST_DIVI,
      (env_ff >= floor_eff) && (env_ff <= 16'd32768), "envelope out of range")

   `ASSERT_IMPLIES(a_rem_below_div, clock, reset, (state_ff == ST_DIV) && !sat_ff,
      rem_ff < env_ff, "divider remainder not below divisor")

   `ASSERT_IMPLIES(a_gain_clamped, clock, reset,
      (state_ff == ST_YMUL) && (min_gain_ff <= max_gain_ff),
      (gain_ff >= min_gain_ff) && (gain_ff <= max_gain_ff), "gain outside limits")

endmodule

// ----- verif/agc_checker.sv -----
// ----------------------------------------------------------------------------
// agc_checker
// Watches the request, response and register channels of the gain control
// block. It keeps its own envelope, gain and register copies, works out the
// gain-scaled sample for every request transaction and compares each response
// transaction field by field, in order.
// ----------------------------------------------------------------------------
module agc_checker
   import agc_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [19:0]                rsp_sample_out,
   input  logic        [15:0]                rsp_gain_now,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                results_due
);

   typedef struct packed {
      logic [19:0] sample_out;
      logic [15:0] gain_now;
   } agc_result_type;

   logic [14:0] target_level_q;
   logic [15:0] level_smoothing_q;
   logic [15:0] gain_smoothing_q;
   logic [15:0] min_gain_q;
   logic [15:0] max_gain_q;
   logic [14:0] level_floor_q;
   logic [15:0] envelope_q;
   logic [15:0] gain_q;

   agc_result_type scaled_samples_due[$];
   agc_result_type oldest;

   function automatic agc_result_type apply_gain_step(
         input logic signed [SAMPLE_WIDTH-1:0] sample);
      longint         s;
      longint         mag;
      longint         floor_level;
      longint         env;
      longint         desired;
      longint         g;
      longint         y;
      agc_result_type r;
      s = longint'(sample);
      mag = (s < 0) ? -s : s;
      floor_level = (level_floor_q == '0) ? 1 : longint'(level_floor_q);
      env = (longint'(level_smoothing_q) * longint'(envelope_q)
             + (65536 - longint'(level_smoothing_q)) * mag + 32768) >>> 16;
      if (env < floor_level) begin
         env = floor_level;
      end
      envelope_q = env[15:0];
      desired = (longint'(target_level_q) << 12) / env;
      if (desired > 65535) begin
         desired = 65535;
      end
      g = (longint'(gain_smoothing_q) * longint'(gain_q)
           + (65536 - longint'(gain_smoothing_q)) * desired + 32768) >>> 16;
      if (g < longint'(min_gain_q)) begin
         g = longint'(min_gain_q);
      end else if (g > longint'(max_gain_q)) begin
         g = longint'(max_gain_q);
      end
      gain_q = g[15:0];
      y = (s * longint'(gain_q)) >>> 12;
      r.sample_out = y[19:0];
      r.gain_now   = gain_q;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         target_level_q    = TARGET_LEVEL_RESET;
         level_smoothing_q = LEVEL_SMOOTHING_RESET;
         gain_smoothing_q  = GAIN_SMOOTHING_RESET;
         min_gain_q        = MIN_GAIN_RESET;
         max_gain_q        = MAX_GAIN_RESET;
         level_floor_q     = LEVEL_FLOOR_RESET;
         envelope_q        = '0;
         gain_q            = UNITY_GAIN;
         fail_count        = 0;
         scaled_samples_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_LEVEL:    target_level_q    = csr_wdata[14:0];
               CSR_LEVEL_SMOOTHING: level_smoothing_q = csr_wdata;
               CSR_GAIN_SMOOTHING:  gain_smoothing_q  = csr_wdata;
               CSR_MIN_GAIN:        min_gain_q        = csr_wdata;
               CSR_MAX_GAIN:        max_gain_q        = csr_wdata;
               CSR_LEVEL_FLOOR:     level_floor_q     = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            scaled_samples_due.push_back(apply_gain_step(req_sample_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (scaled_samples_due.size() == 0) begin
               $display("%0t: unexpected response transaction, sample_out %0d gain_now %0d",
                        $time, rsp_sample_out, rsp_gain_now);
               fail_count = fail_count + 1;
            end else begin
               oldest = scaled_samples_due.pop_front();
               if (oldest.sample_out !== rsp_sample_out) begin
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, $signed(oldest.sample_out), rsp_sample_out);
                  fail_count = fail_count + 1;
               end
               if (oldest.gain_now !== rsp_gain_now) begin
                  $display("%0t: gain_now mismatch, expected %0d actual %0d",
                           $time, oldest.gain_now, rsp_gain_now);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      results_due <= scaled_samples_due.size();
   end

endmodule

// ----- verif/tb_adaptive_gain_control.sv -----
// ----------------------------------------------------------------------------
// tb_adaptive_gain_control
// Drives the gain control block with directed corner samples and register
// settings, then with random audio-like bursts under several register sets
// and handshake idling patterns, including one long response hold-off.
// A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_adaptive_gain_control;
   import agc_pkg::*;

   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES      = 60;
   localparam int SEGMENT_ITEMS     = 152;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample_in = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [19:0]                rsp_sample_out;
   logic        [15:0]                rsp_gain_now;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic        [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic        [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int   fail_count;
   int   results_due;
   int   send_idle_pct = 27;
   int   recv_idle_pct = 63;
   int   quiet_cycles = 0;
   logic stall_armed = 1'b0;
   logic rsp_hold = 1'b0;

   always #10 clock = ~clock;

   adaptive_gain_control DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gain_now   (rsp_gain_now),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   agc_checker CHECKER (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gain_now   (rsp_gain_now),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .results_due    (results_due)
   );

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // hold responses off long enough for the block to back up its input
   initial begin
      wait (stall_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] target, input logic [15:0] lvl_smooth,
                               input logic [15:0] gain_smooth, input logic [15:0] gain_lo,
                               input logic [15:0] gain_hi, input logic [15:0] lvl_floor);
      write_reg(CSR_TARGET_LEVEL, target);
      write_reg(CSR_LEVEL_SMOOTHING, lvl_smooth);
      write_reg(CSR_GAIN_SMOOTHING, gain_smooth);
      write_reg(CSR_MIN_GAIN, gain_lo);
      write_reg(CSR_MAX_GAIN, gain_hi);
      write_reg(CSR_LEVEL_FLOOR, lvl_floor);
      if ($urandom_range(3) == 0) begin
         write_reg($urandom_range(1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO, 16'($urandom));
      end
   endtask

   task automatic send_sample(input logic signed [15:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   function automatic logic [15:0] any_reg_value();
      case ($urandom_range(4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] next_sample(input int amp_bits);
      logic signed [15:0] raw;
      raw = $signed(16'($urandom));
      case ($urandom_range(19))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2:       return 16'sh0000;
         default: return raw >>> (15 - amp_bits);
      endcase
   endfunction

   task automatic run_segment(input int count);
      int amp_bits;
      int run_left;
      amp_bits = 0;
      run_left = 0;
      if ($urandom_range(1)) begin
         program_regs(16'($urandom_range(32767)), 16'($urandom_range(65535, 58000)),
                      16'($urandom_range(65535, 50000)), 16'($urandom_range(8192)),
                      16'($urandom_range(65535, 8192)), 16'($urandom_range(64, 1)));
      end else begin
         program_regs(any_reg_value(), any_reg_value(), any_reg_value(),
                      any_reg_value(), any_reg_value(), any_reg_value());
      end
      csr_valid <= 1'b0;
      repeat (count) begin
         if (run_left == 0) begin
            amp_bits = $urandom_range(15);
            run_left = $urandom_range(60, 10);
         end
         run_left = run_left - 1;
         send_sample(next_sample(amp_bits));
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(-16'sh0001);
      send_sample(16'sh0001);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0000);
      wait_drained();

      // oversize target, zero floor, minimum gain above maximum, no smoothing
      program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'd8000, 16'd2000, 16'h0000);
      write_reg(CSR_UNMAPPED_LO, 16'h1234);
      write_reg(CSR_UNMAPPED_HI, 16'hFFFF);
      csr_valid <= 1'b0;
      send_sample(16'sh0000);
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0003);
      send_sample(-16'sh0003);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      wait_drained();

      program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF);
      csr_valid <= 1'b0;
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sd12345);
      send_sample(-16'sh0001);
      send_sample(16'sh0001);
      wait_drained();

      repeat (4) run_segment(SEGMENT_ITEMS);

      send_idle_pct = 63;
      recv_idle_pct = 27;
      repeat (4) run_segment(SEGMENT_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_armed = 1'b1;
      repeat (4) run_segment(SEGMENT_ITEMS);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/agc_pkg.sv
hw/rtl/adaptive_gain_control.sv
verif/agc_checker.sv
verif/tb_adaptive_gain_control.sv
